// ===== src/rtn_pkg.sv =====
// Package with the shared types, constants and digit lookup for the number-to-text block.
`timescale 1ns / 1ps
`default_nettype none

package rtn_pkg;

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;

  // Number of restoring-division steps done per clock in the back end.
  localparam int STEPS_PER_CYCLE = 8;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_UPPER = 8'h41;

  typedef struct packed {
    logic [4:0] base;
    logic       lowercase;
    logic       treat_unsigned;
  } in_ctrl_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic [4:0] base;
    logic       lowercase;
    logic       negative;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_PRIME,
    BK_SIGN,
    BK_EMIT
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic lower);
    logic [7:0] c;
    if (digit < 4'd10) begin
      c = CHAR_ZERO + {4'd0, digit};
    end else if (lower) begin
      c = CHAR_LOWER + {4'd0, digit} - 8'd10;
    end else begin
      c = CHAR_UPPER + {4'd0, digit} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/rtn_front.sv =====
// Front end: takes an item, clamps the base, resolves the sign and forms the magnitude.
`timescale 1ns / 1ps
`default_nettype none

module rtn_front #(
  parameter int VALUE_BITS
) (
  input  wire logic                                      start,
  input  wire logic [VALUE_BITS-1:0]                     in_value,
  input  wire rtn_pkg::in_ctrl_t                         in_ctrl,
  input  wire logic                                      q_full,
  output logic                                           busy,
  output logic                                           q_push,
  output logic [VALUE_BITS+$bits(rtn_pkg::job_t)-1:0]    q_push_data
);

  rtn_pkg::job_t          job;
  logic [VALUE_BITS-1:0]  magnitude;

  always_comb begin
    job.lowercase = in_ctrl.lowercase;
    if (in_ctrl.base < rtn_pkg::BASE_MIN) begin
      job.base = rtn_pkg::BASE_MIN;
    end else if (in_ctrl.base > rtn_pkg::BASE_MAX) begin
      job.base = rtn_pkg::BASE_MAX;
    end else begin
      job.base = in_ctrl.base;
    end
    job.negative = !in_ctrl.treat_unsigned && in_value[VALUE_BITS-1];
    // The most negative value negates to itself, which read unsigned is its magnitude.
    magnitude = job.negative ? (~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value;
  end

  assign busy        = q_full;
  assign q_push      = start && !q_full;
  assign q_push_data = {job, magnitude};

endmodule

`default_nettype wire

// ===== src/rtn_queue.sv =====
// Small job queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module rtn_queue #(
  parameter int DATA_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   full,
  output logic                   empty
);

  localparam int PW = $clog2(rtn_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(rtn_pkg::QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [rtn_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(rtn_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(rtn_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign full     = (count_r == CW'(rtn_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(rtn_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== src/rtn_back.sv =====
// Back end: divides the magnitude into digits, stores them and emits the characters.
`timescale 1ns / 1ps
`default_nettype none

module rtn_back #(
  parameter int VALUE_BITS
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    q_empty,
  input  wire logic [VALUE_BITS+$bits(rtn_pkg::job_t)-1:0] q_data,
  output logic                                         q_pop,
  output logic                                         out_valid,
  output rtn_pkg::out_item_t                           out_item
);

  localparam int JOB_W  = $bits(rtn_pkg::job_t);
  localparam int STEPS  = rtn_pkg::STEPS_PER_CYCLE;
  localparam int CHUNKS = (VALUE_BITS + STEPS - 1) / STEPS;
  localparam int DIV_W  = CHUNKS * STEPS;
  localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int AW     = $clog2(VALUE_BITS);

  rtn_pkg::back_state_t state_r, state_nxt;
  logic [DIV_W-1:0]     quot_r, quot_nxt;
  logic [3:0]           rem_r, rem_nxt;
  logic [4:0]           base_r, base_nxt;
  logic                 lower_r, lower_nxt;
  logic                 neg_r, neg_nxt;
  logic [CHW-1:0]       chunk_r, chunk_nxt;
  logic [AW-1:0]        digit_idx_r, digit_idx_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;

  rtn_pkg::job_t        job_in;
  logic [DIV_W-1:0]     step_q;
  logic [3:0]           step_r;
  logic                 wr_en;

  logic [3:0]           digit_mem [VALUE_BITS];
  logic [3:0]           rd_q_r;

  assign job_in = q_data[VALUE_BITS +: JOB_W];

  // Restoring division, a fixed number of quotient bits per cycle; the remainder stays
  // below the base, so every step is a narrow compare and subtract.
  always_comb begin
    logic [4:0] t;
    step_q = quot_r;
    step_r = rem_r;
    for (int i = 0; i < STEPS; i++) begin
      t      = {step_r, step_q[DIV_W-1]};
      step_q = {step_q[DIV_W-2:0], 1'b0};
      if (t >= base_r) begin
        t         = t - base_r;
        step_q[0] = 1'b1;
      end
      step_r = t[3:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    base_nxt      = base_r;
    lower_nxt     = lower_r;
    neg_nxt       = neg_r;
    chunk_nxt     = chunk_r;
    digit_idx_nxt = digit_idx_r;
    ptr_nxt       = ptr_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    out_valid     = 1'b0;
    out_item      = '0;
    case (state_r)
      rtn_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          quot_nxt      = DIV_W'(q_data[VALUE_BITS-1:0]);
          rem_nxt       = '0;
          base_nxt      = job_in.base;
          lower_nxt     = job_in.lowercase;
          neg_nxt       = job_in.negative;
          chunk_nxt     = '0;
          digit_idx_nxt = '0;
          state_nxt     = rtn_pkg::BK_DIVIDE;
        end
      end
      rtn_pkg::BK_DIVIDE: begin
        quot_nxt = step_q;
        rem_nxt  = step_r;
        if (chunk_r == CHW'(CHUNKS - 1)) begin
          wr_en     = 1'b1;
          chunk_nxt = '0;
          rem_nxt   = '0;
          if (step_q != '0 && digit_idx_r != AW'(VALUE_BITS - 1)) begin
            digit_idx_nxt = digit_idx_r + 1'b1;
          end else begin
            ptr_nxt   = digit_idx_r;
            state_nxt = rtn_pkg::BK_PRIME;
          end
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      rtn_pkg::BK_PRIME: begin
        // Waits for the registered read of the top digit.
        state_nxt = neg_r ? rtn_pkg::BK_SIGN : rtn_pkg::BK_EMIT;
      end
      rtn_pkg::BK_SIGN: begin
        out_valid          = 1'b1;
        out_item.character = rtn_pkg::CHAR_MINUS;
        out_item.last      = 1'b0;
        state_nxt          = rtn_pkg::BK_EMIT;
      end
      rtn_pkg::BK_EMIT: begin
        out_valid          = 1'b1;
        out_item.character = rtn_pkg::digit_char(rd_q_r, lower_r);
        out_item.last      = (ptr_r == '0);
        if (ptr_r == '0) begin
          state_nxt = rtn_pkg::BK_IDLE;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      default: begin
        state_nxt = rtn_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtn_pkg::BK_IDLE;
      chunk_r <= '0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r      <= quot_nxt;
    rem_r       <= rem_nxt;
    base_r      <= base_nxt;
    lower_r     <= lower_nxt;
    neg_r       <= neg_nxt;
    digit_idx_r <= digit_idx_nxt;
    ptr_r       <= ptr_nxt;
  end

  // Digit store: written at the current digit, read at the next output position.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[digit_idx_r] <= step_r;
    end
    rd_q_r <= digit_mem[ptr_nxt];
  end

`ifndef SYNTHESIS
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == rtn_pkg::BK_IDLE)
    else $error("job taken while the back end is working");
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> state_r == rtn_pkg::BK_IDLE)
    else $error("back end did not return to idle after the last character");
  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rtn_pkg::BK_DIVIDE |-> digit_idx_r <= AW'(VALUE_BITS - 1))
    else $error("digit index past the store");
`endif

endmodule

`default_nettype wire

// ===== src/radix_number_to_text_top.sv =====
// Top level of the number-to-text block: front end, job queue and back end.
//
//   channel  ports                       handshake
//   input    start, busy, in_value,      taken at a rising edge with start high
//            in_ctrl                     and busy low
//   result   out_valid, out_item         one character per strobe cycle, no backpressure
//
// The back end pops a job when idle, divides the magnitude into D digits, primes the
// read of the top digit, sends a minus sign if negative and then the D digits, and takes
// no new job until idle again; the division unit settles eight quotient bits per cycle.
// Reset is synchronous, active low, and empties the queue and idles the back end.
// busy rises only when the two-entry queue is full; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module radix_number_to_text_top #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire rtn_pkg::in_ctrl_t     in_ctrl,
  output logic                       out_valid,
  output rtn_pkg::out_item_t         out_item
);

  localparam int Q_W = VALUE_BITS + $bits(rtn_pkg::job_t);

  logic           q_push;
  logic [Q_W-1:0] q_push_data;
  logic           q_pop;
  logic [Q_W-1:0] q_pop_data;
  logic           q_full;
  logic           q_empty;

  rtn_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .start       (start),
    .in_value    (in_value),
    .in_ctrl     (in_ctrl),
    .q_full      (q_full),
    .busy        (busy),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  rtn_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rtn_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== tb/sv/radix_number_to_text_top_test.sv =====
// Self-checking testbench for the radix number-to-text block.
`timescale 1ns / 1ps

module radix_number_to_text_top_test;

  localparam int VALUE_BITS = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 200;

  class text_scoreboard;
    rtn_pkg::out_item_t expected_chars[$];
    int errors;
    int numbers_noted;
    int chars_checked;

    // Splits the number into digits by repeated division, then lays out the
    // text most significant character first, sign ahead of the digits.
    function void note_number(logic [VALUE_BITS-1:0] value, rtn_pkg::in_ctrl_t ctrl);
      string lower_set;
      string upper_set;
      logic [4:0] radix;
      logic negative;
      logic [VALUE_BITS-1:0] quotient;
      logic [3:0] digits[$];
      rtn_pkg::out_item_t item;
      lower_set = "0123456789abcdef";
      upper_set = "0123456789ABCDEF";
      radix = ctrl.base;
      if (radix < 5'd2) radix = 5'd2;
      if (radix > 5'd16) radix = 5'd16;
      negative = !ctrl.treat_unsigned && value[VALUE_BITS-1];
      quotient = negative ? -value : value;
      do begin
        digits.push_back(4'(quotient % radix));
        quotient = quotient / radix;
      end while (quotient != 0);
      if (negative) begin
        item.character = 8'h2D;
        item.last = 1'b0;
        expected_chars.push_back(item);
      end
      for (int k = digits.size() - 1; k >= 0; k--) begin
        item.character = ctrl.lowercase ? lower_set[digits[k]] : upper_set[digits[k]];
        item.last = (k == 0);
        expected_chars.push_back(item);
      end
      numbers_noted++;
    endfunction

    function void check_char(rtn_pkg::out_item_t got);
      rtn_pkg::out_item_t want;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, got.character, got.last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (got.character !== want.character) begin
        $display("%0t: character mismatch, expected %h actual %h",
                 $time, want.character, got.character);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [VALUE_BITS-1:0] in_value = '0;
  rtn_pkg::in_ctrl_t in_ctrl = '0;
  logic out_valid;
  rtn_pkg::out_item_t out_item;

  text_scoreboard sb = new;
  int cycle_count = 0;
  int idle_pct = 0;

  radix_number_to_text_top #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .in_ctrl(in_ctrl),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_char(out_item);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("FAIL radix_number_to_text_top");
    $finish;
  end

  // Called just after a rising edge; returns at the edge that takes the item.
  task send_number(logic [VALUE_BITS-1:0] value, logic [4:0] base, logic lower,
                   logic uns);
    rtn_pkg::in_ctrl_t ctrl;
    ctrl.base = base;
    ctrl.lowercase = lower;
    ctrl.treat_unsigned = uns;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_value <= value;
    in_ctrl <= ctrl;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_number(value, ctrl);
  endtask

  task wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task run_directed();
    send_number(32'd0, 5'd10, 1'b0, 1'b0);
    send_number(32'h7FFF_FFFF, 5'd10, 1'b0, 1'b0);
    // The most negative value must convert its full magnitude.
    send_number(32'h8000_0000, 5'd10, 1'b0, 1'b0);
    send_number(32'h8000_0000, 5'd2, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF, 5'd2, 1'b1, 1'b1);
    send_number(32'hFFFF_FFFF, 5'd16, 1'b0, 1'b0);
    send_number(32'hDEAD_BEEF, 5'd16, 1'b1, 1'b1);
    send_number(32'hDEAD_BEEF, 5'd16, 1'b0, 1'b1);
    send_number(32'hDEAD_BEEF, 5'd16, 1'b1, 1'b0);
    send_number(32'd5, 5'd0, 1'b0, 1'b0);
    send_number(32'd5, 5'd1, 1'b0, 1'b0);
    send_number(32'd255, 5'd17, 1'b1, 1'b0);
    send_number(32'd255, 5'd31, 1'b0, 1'b0);
    send_number(32'd0, 5'd0, 1'b1, 1'b1);
    send_number(32'hFFFF_FFF6, 5'd10, 1'b0, 1'b0);
    send_number(32'd123456789, 5'd3, 1'b0, 1'b0);
    send_number(32'd987654321, 5'd7, 1'b0, 1'b1);
    send_number(32'h0FED_CBA9, 5'd11, 1'b1, 1'b0);
    send_number(32'h0FED_CBA9, 5'd13, 1'b0, 1'b0);
    send_number(32'hFFFF_0000, 5'd15, 1'b1, 1'b0);
    send_number(32'd1, 5'd9, 1'b0, 1'b1);
  endtask

  function logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom_range(0, 20);
      1: return -$urandom_range(1, 20);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      4: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task run_random(int count, int pct);
    logic [4:0] base;
    idle_pct = pct;
    repeat (count) begin
      base = ($urandom_range(99) < 85) ? 5'($urandom_range(2, 16)) : 5'($urandom_range(0, 31));
      send_number(pick_value(), base, 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    wait_drained();
    run_random(67, 23);
    wait_drained();
    run_random(67, 68);
    wait_drained();
    run_random(66, 0);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d numbers into %0d checked characters across all base codes,",
             sb.numbers_noted, sb.chars_checked);
    $display("signed and unsigned, both letter cases, under three sender idle profiles.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS radix_number_to_text_top");
    end else begin
      $display("FAIL radix_number_to_text_top");
    end
    $finish;
  end

endmodule
